// File: rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Shared types, character codes and the alphabet lookup for the decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Default depth of the result queue; it must hold at least two beats.
    localparam int unsigned RES_FIFO_DEPTH = 4;

    // Character codes.
    localparam logic [7:0] PAD_CHAR        = 8'h3D;
    localparam logic [7:0] CHAR_PLUS       = 8'h2B;
    localparam logic [7:0] CHAR_SLASH      = 8'h2F;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    // Configuration register indexes.
    localparam logic [0:0] REG_URL_ALPHABET  = 1'b0;
    localparam logic [0:0] REG_ALLOW_PADDING = 1'b1;

    // One result beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_status;
        logic       error_flag;
        logic       final_item;
    } t_result;

    // Lookup result: valid is low for characters outside the alphabet.
    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    // Map one character to its 6-bit value in the selected alphabet.
    function automatic t_sextet sextet_of(input logic [7:0] c, input logic url);
        t_sextet    s;
        logic [7:0] t;
        s.valid = 1'b1;
        s.value = '0;
        t       = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            t       = c - 8'h41;
            s.value = t[5:0];
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            // 26 + (c - 'a')
            t       = c - 8'h47;
            s.value = t[5:0];
        end else if (c >= 8'h30 && c <= 8'h39) begin
            // 52 + (c - '0')
            t       = c + 8'd4;
            s.value = t[5:0];
        end else if (c == (url ? CHAR_MINUS : CHAR_PLUS)) begin
            s.value = 6'd62;
        end else if (c == (url ? CHAR_UNDERSCORE : CHAR_SLASH)) begin
            s.value = 6'd63;
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

// File: rtl/b64d_res_fifo.sv
// ----------------------------------------------------------------------------
// Base64 decoder result queue
// Small register queue that takes up to two result beats per cycle and
// presents one beat per cycle on the output stream while i_pop is high.
// ----------------------------------------------------------------------------
module b64d_res_fifo #(
    parameter int unsigned DEPTH = b64d_pkg::RES_FIFO_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_push_cnt,
    input  b64d_pkg::t_result            i_entry0,
    input  b64d_pkg::t_result            i_entry1,
    input  logic                         i_pop,
    output logic                         o_valid,
    output b64d_pkg::t_result            o_head,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    // Advance a pointer by one, wrapping at the depth.
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    b64d_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_count, n_count;
    logic [PW-1:0]     wr_ptr_1;
    logic              pop_ok;

    assign wr_ptr_1 = ptr_inc(r_wr_ptr);
    assign pop_ok   = i_pop && (r_count != '0);

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push_cnt == 2'd1) begin
            n_wr_ptr = wr_ptr_1;
        end else if (i_push_cnt == 2'd2) begin
            n_wr_ptr = ptr_inc(wr_ptr_1);
        end
        n_rd_ptr = pop_ok ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CW'(i_push_cnt) - CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage; the second beat lands one slot after the first.
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_entry0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr_1] <= i_entry1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes a base64 character stream (standard or URL-safe alphabet) into
// bytes and closes each message with an ok or error status beat.
// ----------------------------------------------------------------------------
// The decoder takes one character per clock cycle while tready is high. Each
// character is decoded in the cycle it is accepted and its results (at most
// one data byte, plus a status beat when tlast marks the end of the message)
// are written to a small result queue that drives the output stream one beat
// per cycle when ready. A character that carries the end mark and also
// completes a byte produces two output beats, so such runs stall the input;
// all others sustain one character per cycle unless the output stalls. Input
// tready stays high while the queue has room for two beats. Errors are sticky
// within a message and stop further data bytes; when the status beat reports
// an error, the bytes of that message already delivered must be discarded.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
    parameter int unsigned FIFO_DEPTH = b64d_pkg::RES_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Character stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_of_message
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
    output logic [1:0]  m_axis_tuser,   // [0] is_status, [1] error_flag
    output logic        m_axis_tlast    // final_item
);

    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

    // Configuration registers.
    logic r_url_alphabet;
    logic r_allow_padding;

    // Message state.
    logic [1:0] r_pos,  n_pos;
    logic [5:0] r_prev, n_prev;
    logic       r_pad,  n_pad;
    logic       r_err,  n_err;

    logic              in_beat;
    logic              is_pad;
    b64d_pkg::t_sextet sx;
    logic [7:0]        dec_byte;
    logic              data_v;
    logic [1:0]        push_cnt;
    b64d_pkg::t_result data_res, stat_res, entry0, entry1, head;
    logic              q_valid;
    logic [CW-1:0]     q_count;

    // Configuration write and read.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_url_alphabet  <= 1'b0;
            r_allow_padding <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                b64d_pkg::REG_URL_ALPHABET:  r_url_alphabet  <= pwdata[0];
                b64d_pkg::REG_ALLOW_PADDING: r_allow_padding <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            b64d_pkg::REG_URL_ALPHABET:  prdata = {31'b0, r_url_alphabet};
            b64d_pkg::REG_ALLOW_PADDING: prdata = {31'b0, r_allow_padding};
            default:                     prdata = '0;
        endcase
    end

    // Input handshake: room for two result beats is required.
    assign s_axis_tready = (q_count <= CW'(FIFO_DEPTH - 2));
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign is_pad = (s_axis_tdata == b64d_pkg::PAD_CHAR);
    assign sx     = b64d_pkg::sextet_of(s_axis_tdata, r_url_alphabet);

    // Byte assembly from the previous and current sextets.
    always_comb begin
        case (r_pos)
            2'd1:    dec_byte = {r_prev, sx.value[5:4]};
            2'd2:    dec_byte = {r_prev[3:0], sx.value[5:2]};
            2'd3:    dec_byte = {r_prev[1:0], sx.value};
            default: dec_byte = '0;
        endcase
    end

    // Per-character state update and error checks.
    always_comb begin
        n_pos  = r_pos + 2'd1;
        n_prev = r_prev;
        n_pad  = r_pad;
        n_err  = r_err;
        data_v = 1'b0;
        if (is_pad) begin
            if (!r_allow_padding || r_pos < 2'd2) begin
                n_err = 1'b1;
            end
            n_pad = 1'b1;
        end else if (r_pad || !sx.valid) begin
            n_err = 1'b1;
        end else begin
            data_v = (r_pos != 2'd0) && !r_err;
            n_prev = sx.value;
        end
        if (s_axis_tlast) begin
            // Bad final length, or padding that does not close the group.
            if (r_pos == 2'd0 || (n_pad && r_pos != 2'd3)) begin
                n_err = 1'b1;
            end
        end
    end

    // Result beats for this character.
    always_comb begin
        data_res.data_byte  = dec_byte;
        data_res.is_status  = 1'b0;
        data_res.error_flag = 1'b0;
        data_res.final_item = 1'b0;
        stat_res.data_byte  = '0;
        stat_res.is_status  = 1'b1;
        stat_res.error_flag = n_err;
        stat_res.final_item = 1'b1;
        entry0   = data_v ? data_res : stat_res;
        entry1   = stat_res;
        push_cnt = 2'd0;
        if (in_beat) begin
            push_cnt = {1'b0, data_v} + {1'b0, s_axis_tlast};
        end
    end

    // State registers; the end mark returns the message state to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_prev <= '0;
            r_pad  <= 1'b0;
            r_err  <= 1'b0;
        end else if (in_beat) begin
            if (s_axis_tlast) begin
                r_pos  <= '0;
                r_prev <= '0;
                r_pad  <= 1'b0;
                r_err  <= 1'b0;
            end else begin
                r_pos  <= n_pos;
                r_prev <= n_prev;
                r_pad  <= n_pad;
                r_err  <= n_err;
            end
        end
    end

    // Result queue feeding the output stream.
    b64d_res_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_res_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_entry0   (entry0),
        .i_entry1   (entry1),
        .i_pop      (m_axis_tready),
        .o_valid    (q_valid),
        .o_head     (head),
        .o_count    (q_count)
    );

    assign m_axis_tvalid = q_valid;
    assign m_axis_tdata  = head.data_byte;
    assign m_axis_tuser  = {head.error_flag, head.is_status};
    assign m_axis_tlast  = head.final_item;

`ifndef SYNTHESIS
    // The queue never overflows its depth.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    // An end-of-message beat leaves the group position at the start.
    a_eom_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && s_axis_tlast) |=> (r_pos == 2'd0 && !r_err && !r_pad))
        else $error("message state not cleared after end mark");

    // A data beat never carries the error or final marks.
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (!m_axis_tuser[1] && !m_axis_tlast))
        else $error("data beat carries status marks");
`endif

endmodule
